/* hw/rtl/tfwf_pkg.sv */
// ----------------------------------------------------------------------------
// tfwf_pkg
// Shared sizes, types and the cosine table of the weighting filter.
// ----------------------------------------------------------------------------
package tfwf_pkg;

  localparam int FFT_SIZE = 64;
  localparam int NW       = FFT_SIZE / 2 + 1;
  localparam int AW       = $clog2(FFT_SIZE);
  localparam int CW       = AW + 1;
  localparam int KW       = $clog2(NW);
  localparam int TSH      = 6 - AW;
  localparam int SW       = 20;
  localparam int HW       = 35;

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic CFG_ADJOINT    = 1'b0;
  localparam logic CFG_ACCUMULATE = 1'b1;

  localparam logic signed [16:0] QCOS [17] = '{
    17'sd32768, 17'sd32610, 17'sd32138, 17'sd31357, 17'sd30274, 17'sd28899,
    17'sd27246, 17'sd25330, 17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447,
    17'sd12540, 17'sd9512, 17'sd6393, 17'sd3212, 17'sd0
  };

  typedef struct packed {
    logic adjoint;
    logic accumulate;
  } cfg_t;

  typedef struct packed {
    logic [CW-1:0] count;
  } trace_cmd_t;

  typedef struct packed {
    logic                 bw_we;
    logic [KW-1:0]        bw_addr;
    logic signed [15:0]   bw_data;
    logic                 s_we;
    logic [AW-1:0]        s_addr;
    logic signed [15:0]   sw_data;
    logic signed [15:0]   pr_data;
    logic signed [SW-1:0] xs_data;
  } wr_t;

  function automatic logic signed [16:0] cos_q15(input logic [5:0] i);
    logic [1:0]         q;
    logic [3:0]         r;
    logic signed [16:0] a;
    logic signed [16:0] b;
    q = i[5:4];
    r = i[3:0];
    a = QCOS[r];
    b = QCOS[5'd16 - {1'b0, r}];
    case (q)
      2'd0:    return a;
      2'd1:    return -b;
      2'd2:    return -a;
      default: return b;
    endcase
  endfunction

endpackage

/* hw/rtl/tfwf_ram.sv */
// ----------------------------------------------------------------------------
// tfwf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfwf_ram #(
  parameter int W = 16,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tfwf_queue.sv */
// ----------------------------------------------------------------------------
// tfwf_queue
// Two-entry queue of finished traces between the front and back parts.
// ----------------------------------------------------------------------------
module tfwf_queue import tfwf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  trace_cmd_t push_cmd,
  input  logic       pop,
  output logic       q_valid,
  output trace_cmd_t q_cmd
);

  trace_cmd_t ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rp_r];
  assign do_push = push && (cnt_r != 2'd2);
  assign do_pop  = pop && q_valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/tfwf_front.sv */
// ----------------------------------------------------------------------------
// tfwf_front
// Accepts beats, stores bin weights and trace samples, and queues each trace.
// ----------------------------------------------------------------------------
module tfwf_front import tfwf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        in_tdata,
  input  logic               in_tuser,
  input  logic               in_tlast,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_data,
  input  logic               trace_done,
  output cfg_t               cfg,
  output wr_t                wr,
  output logic               push,
  output trace_cmd_t         push_cmd
);

  logic               adj_r, acc_r;
  logic               pend_r, pend_nxt;
  logic [KW-1:0]      bidx_r, bidx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               acc_beat;
  logic signed [15:0] x, w;
  logic signed [31:0] xw, xw_rnd;
  logic [CW-1:0]      cnt_inc;
  logic               trace_end;

  assign in_tready = !pend_r;
  assign acc_beat  = in_tvalid && in_tready;
  assign x         = in_tdata[15:0];
  assign w         = in_tdata[31:16];
  assign xw        = x * w;
  assign xw_rnd    = xw + 32'sd2048;
  assign cnt_inc   = cnt_r + CW'(1);
  assign trace_end = in_tlast || (cnt_inc == CW'(FFT_SIZE));

  assign cfg.adjoint    = adj_r;
  assign cfg.accumulate = acc_r;

  always_comb begin
    wr.bw_we   = acc_beat && (in_tuser == FUNC_WEIGHT);
    wr.bw_addr = bidx_r;
    wr.bw_data = in_tdata[47:32];
    wr.s_we    = acc_beat && (in_tuser == FUNC_SAMPLE);
    wr.s_addr  = cnt_r[AW-1:0];
    wr.sw_data = w;
    wr.pr_data = in_tdata[63:48];
    wr.xs_data = adj_r ? xw_rnd[31:12] : SW'(x);
    push           = wr.s_we && trace_end;
    push_cmd.count = cnt_inc;
  end

  always_comb begin
    pend_nxt = pend_r;
    bidx_nxt = bidx_r;
    cnt_nxt  = cnt_r;
    if (trace_done) begin
      pend_nxt = 1'b0;
    end
    if (wr.bw_we) begin
      bidx_nxt = (bidx_r == KW'(NW - 1)) ? '0 : bidx_r + KW'(1);
    end
    if (wr.s_we) begin
      cnt_nxt = cnt_inc;
      if (trace_end) begin
        cnt_nxt  = '0;
        bidx_nxt = '0;
        pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_r  <= 1'b0;
      acc_r  <= 1'b0;
      pend_r <= 1'b0;
      bidx_r <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      bidx_r <= bidx_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_we && (cfg_index == CFG_ADJOINT)) begin
        adj_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_ACCUMULATE)) begin
        acc_r <= cfg_data;
      end
    end
  end

endmodule

/* hw/rtl/tfwf_back.sv */
// ----------------------------------------------------------------------------
// tfwf_back
// Builds the filter kernel from the bin weights, convolves the trace and
// emits one weighted, saturated result per sample.
// ----------------------------------------------------------------------------
module tfwf_back import tfwf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 q_valid,
  input  trace_cmd_t           q_cmd,
  output logic                 pop,
  output logic [KW-1:0]        bw_raddr,
  input  logic signed [15:0]   bw_rdata,
  output logic [AW-1:0]        s_raddr,
  input  logic signed [15:0]   sw_rdata,
  input  logic signed [15:0]   pr_rdata,
  input  logic signed [SW-1:0] xs_rdata,
  output logic                 h_we,
  output logic [AW-1:0]        h_waddr,
  output logic signed [HW-1:0] h_wdata,
  output logic [AW-1:0]        h_raddr,
  input  logic signed [HW-1:0] h_rdata,
  output logic                 trace_done,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  output logic                 out_tuser,
  output logic                 out_tlast
);

  typedef enum logic [3:0] {
    S_IDLE, S_K_RD, S_K_MUL, S_K_ACC, S_K_WR, S_C_RD, S_C_MUL, S_C_ACC,
    S_O_MUL, S_O_SCL, S_O_FIN, S_O_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        m_r, m_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [AW-1:0]        p_r, p_nxt;
  logic [AW-1:0]        j_r, j_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [37:0]   kacc_r, kacc_nxt;
  logic signed [32:0]   prod_r, prod_nxt;
  logic                 dbl_r, dbl_nxt;
  logic signed [55:0]   cacc_r, cacc_nxt;
  logic signed [38:0]   p1_r, p1_nxt;
  logic signed [36:0]   p2_r, p2_nxt;
  logic signed [29:0]   u_r, u_nxt;
  logic signed [36:0]   v_r, v_nxt;
  logic                 ov_r, ov_nxt;
  logic [15:0]          od_r, od_nxt;
  logic                 ol_r, ol_nxt;
  logic                 os_r, os_nxt;
  logic                 done_r, done_nxt;

  logic signed [37:0]   hsum;
  logic signed [56:0]   csum;
  logic signed [45:0]   uw;
  logic signed [45:0]   uw_rnd;
  logic signed [37:0]   vt;
  logic                 j_last, m_last;

  assign bw_raddr   = k_r;
  assign s_raddr    = (state_r == S_C_RD || state_r == S_C_MUL) ? j_r : m_r;
  assign h_raddr    = m_r - j_r;
  assign h_we       = (state_r == S_K_WR);
  assign h_waddr    = m_r;
  assign hsum       = kacc_r + 38'(FFT_SIZE / 2);
  assign h_wdata    = HW'(hsum >>> AW);
  assign csum       = 57'(cacc_r) + 57'sd67108864;
  assign uw         = u_r * sw_rdata;
  assign uw_rnd     = uw + 46'sd2048;
  assign vt         = 38'(v_r) + (cfg.accumulate ? 38'(pr_rdata) : 38'sd0);
  assign j_last     = ({1'b0, j_r} + CW'(1)) == cnt_r;
  assign m_last     = ({1'b0, m_r} + CW'(1)) == cnt_r;
  assign pop        = (state_r == S_IDLE) && q_valid;
  assign trace_done = done_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = os_r;

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    kacc_nxt  = kacc_r;
    prod_nxt  = prod_r;
    dbl_nxt   = dbl_r;
    cacc_nxt  = cacc_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    os_nxt    = os_r;
    done_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cnt_nxt   = q_cmd.count;
          m_nxt     = '0;
          k_nxt     = '0;
          p_nxt     = '0;
          kacc_nxt  = '0;
          state_nxt = S_K_RD;
        end
      end
      S_K_RD: begin
        state_nxt = S_K_MUL;
      end
      S_K_MUL: begin
        prod_nxt  = bw_rdata * cos_q15(6'(p_r) << TSH);
        dbl_nxt   = (k_r != '0) && (k_r != KW'(FFT_SIZE / 2));
        state_nxt = S_K_ACC;
      end
      S_K_ACC: begin
        kacc_nxt = kacc_r + (dbl_r ? (38'(prod_r) <<< 1) : 38'(prod_r));
        if (k_r == KW'(NW - 1)) begin
          state_nxt = S_K_WR;
        end else begin
          k_nxt     = k_r + KW'(1);
          p_nxt     = p_r + m_r;
          state_nxt = S_K_RD;
        end
      end
      S_K_WR: begin
        k_nxt    = '0;
        p_nxt    = '0;
        kacc_nxt = '0;
        j_nxt    = '0;
        cacc_nxt = '0;
        if (m_r == AW'(FFT_SIZE - 1)) begin
          m_nxt     = '0;
          state_nxt = S_C_RD;
        end else begin
          m_nxt     = m_r + AW'(1);
          state_nxt = S_K_RD;
        end
      end
      S_C_RD: begin
        state_nxt = S_C_MUL;
      end
      S_C_MUL: begin
        p1_nxt    = $signed({1'b0, h_rdata[17:0]}) * xs_rdata;
        p2_nxt    = $signed(h_rdata[HW-1:18]) * xs_rdata;
        state_nxt = S_C_ACC;
      end
      S_C_ACC: begin
        cacc_nxt = cacc_r + 56'(p1_r) + (56'(p2_r) <<< 18);
        if (j_last) begin
          state_nxt = S_O_MUL;
        end else begin
          j_nxt     = j_r + AW'(1);
          state_nxt = S_C_RD;
        end
      end
      S_O_MUL: begin
        u_nxt     = csum[56:27];
        state_nxt = S_O_SCL;
      end
      S_O_SCL: begin
        v_nxt     = cfg.adjoint ? 37'(u_r) : 37'(uw_rnd >>> 12);
        state_nxt = S_O_FIN;
      end
      S_O_FIN: begin
        ov_nxt = 1'b1;
        ol_nxt = m_last;
        if (vt > 38'sd32767) begin
          od_nxt = 16'h7FFF;
          os_nxt = 1'b1;
        end else if (vt < -38'sd32768) begin
          od_nxt = 16'h8000;
          os_nxt = 1'b1;
        end else begin
          od_nxt = vt[15:0];
          os_nxt = 1'b0;
        end
        state_nxt = S_O_OUT;
      end
      S_O_OUT: begin
        if (out_tready) begin
          ov_nxt = 1'b0;
          if (m_last) begin
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            m_nxt     = m_r + AW'(1);
            j_nxt     = '0;
            cacc_nxt  = '0;
            state_nxt = S_C_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      done_r  <= done_nxt;
    end
    m_r    <= m_nxt;
    k_r    <= k_nxt;
    p_r    <= p_nxt;
    j_r    <= j_nxt;
    cnt_r  <= cnt_nxt;
    kacc_r <= kacc_nxt;
    prod_r <= prod_nxt;
    dbl_r  <= dbl_nxt;
    cacc_r <= cacc_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
    os_r   <= os_nxt;
  end

endmodule

/* hw/rtl/time_frequency_weight_filter.sv */
// ----------------------------------------------------------------------------
// time_frequency_weight_filter
// Weight and sample beats are accepted back to back while input is ready.
// After the last sample the kernel is built for all FFT_SIZE taps from the
// NW bin weights, and each result is then a convolution over the n samples.
// Input stalls from the end of a trace and is ready again once its last
// result is taken, which is registered in done_r and then in pend_r.
// Reset is synchronous; sample and weight memories are not cleared.
// ----------------------------------------------------------------------------
module time_frequency_weight_filter import tfwf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sample_value, time_weight, freq_weight, prior_value
  input  logic        in_tuser,   // func
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // result_value
  output logic        out_tuser,  // saturated
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  cfg_t                 cfg;
  wr_t                  wr;
  logic                 push, pop, q_valid, trace_done;
  trace_cmd_t           push_cmd, q_cmd;
  logic [KW-1:0]        bw_raddr;
  logic [15:0]          bw_rdata, sw_rdata, pr_rdata;
  logic [AW-1:0]        s_raddr, h_waddr, h_raddr;
  logic [SW-1:0]        xs_rdata;
  logic                 h_we;
  logic [HW-1:0]        h_wdata, h_rdata;

  tfwf_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .cfg_we, .cfg_index, .cfg_data, .trace_done, .cfg, .wr, .push, .push_cmd
  );

  tfwf_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .pop, .q_valid, .q_cmd
  );

  tfwf_ram #(.W(16), .D(NW)) u_bw_ram (
    .clk, .we(wr.bw_we), .waddr(wr.bw_addr), .wdata(wr.bw_data),
    .raddr(bw_raddr), .rdata(bw_rdata)
  );

  tfwf_ram #(.W(16), .D(FFT_SIZE)) u_sw_ram (
    .clk, .we(wr.s_we), .waddr(wr.s_addr), .wdata(wr.sw_data),
    .raddr(s_raddr), .rdata(sw_rdata)
  );

  tfwf_ram #(.W(16), .D(FFT_SIZE)) u_pr_ram (
    .clk, .we(wr.s_we), .waddr(wr.s_addr), .wdata(wr.pr_data),
    .raddr(s_raddr), .rdata(pr_rdata)
  );

  tfwf_ram #(.W(SW), .D(FFT_SIZE)) u_xs_ram (
    .clk, .we(wr.s_we), .waddr(wr.s_addr), .wdata(wr.xs_data),
    .raddr(s_raddr), .rdata(xs_rdata)
  );

  tfwf_ram #(.W(HW), .D(FFT_SIZE)) u_h_ram (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  tfwf_back u_back (
    .clk, .rst_n, .cfg, .q_valid, .q_cmd, .pop,
    .bw_raddr, .bw_rdata(signed'(bw_rdata)),
    .s_raddr, .sw_rdata(signed'(sw_rdata)), .pr_rdata(signed'(pr_rdata)),
    .xs_rdata(signed'(xs_rdata)),
    .h_we, .h_waddr, .h_wdata, .h_raddr, .h_rdata(signed'(h_rdata)),
    .trace_done, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule

/* bench/time_frequency_weight_filter_tb.sv */
// ----------------------------------------------------------------------------
// time_frequency_weight_filter_tb
// Self-checking bench for the time and frequency weighting filter. Bin
// weights and traces are streamed in; every result beat is compared with a
// bit-exact prediction of the circular convolution, time weighting,
// accumulation and saturation, under all four mode settings and several
// patterns of source gaps and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_frequency_weight_filter_tb;
  import tfwf_pkg::*;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
    logic               sat;
  } filt_result_t;

  typedef struct {
    int   x;
    int   w;
    int   pv;
    logic last;
    logic typed;
    int   ev;
    logic es;
  } trace_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_data = 1'b0;

  filt_result_t expected_q[$];
  int           error_count = 0;
  int           items_sent = 0;
  int           gap_pct = 0;
  int           stall_pct = 0;
  logic         hold_start = 1'b0;
  int           hold_left = 0;

  logic         mode_adjoint = 1'b0;
  logic         mode_accum = 1'b0;
  int           bin_w[NW];
  int           tw_store[FFT_SIZE];
  int           prior_mem[FFT_SIZE];
  longint       xs_store[FFT_SIZE];
  int           bin_idx = 0;
  int           trace_len = 0;

  trace_row_t directed_rows[12] = '{
    '{0, 4096, 0, 1'b1, 1'b1, 0, 1'b0},
    '{32767, 4096, 0, 1'b1, 1'b1, 32767, 1'b0},
    '{-32768, 4096, 0, 1'b1, 1'b1, -32768, 1'b0},
    '{32767, -32768, 0, 1'b1, 1'b1, -32768, 1'b1},
    '{-32768, -32768, 0, 1'b1, 1'b1, 32767, 1'b1},
    '{16384, 8192, 0, 1'b1, 1'b1, 32767, 1'b1},
    '{1, 2048, 0, 1'b1, 1'b1, 1, 1'b0},
    '{-1, 2048, 0, 1'b1, 1'b1, 0, 1'b0},
    '{12000, 3000, -7000, 1'b0, 1'b0, 0, 1'b0},
    '{-20000, -4096, 32767, 1'b0, 1'b0, 0, 1'b0},
    '{300, 40, -32768, 1'b0, 1'b0, 0, 1'b0},
    '{-9, 9000, 5, 1'b1, 1'b0, 0, 1'b0}
  };

  time_frequency_weight_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint round_div(longint a, longint d);
    longint b;
    b = a + d / 2;
    if (b >= 0) return b / d;
    return -((-b + d - 1) / d);
  endfunction

  function automatic longint cos_table(int i);
    int q;
    int r;
    q = (i >> 4) & 3;
    r = i & 15;
    case (q)
      0:       return QCOS[r];
      1:       return -QCOS[16 - r];
      2:       return -QCOS[r];
      default: return QCOS[16 - r];
    endcase
  endfunction

  task automatic filter_trace();
    longint       kern[FFT_SIZE];
    longint       acc;
    longint       v;
    filt_result_t r;
    for (int m = 0; m < FFT_SIZE; m++) begin
      acc = 0;
      for (int k = 0; k < NW; k++) begin
        acc += ((k == 0 || k == FFT_SIZE / 2) ? 1 : 2) * longint'(bin_w[k]) *
               cos_table(((k * m) % FFT_SIZE) * (64 / FFT_SIZE));
      end
      kern[m] = round_div(acc, FFT_SIZE);
    end
    for (int m = 0; m < trace_len; m++) begin
      acc = 0;
      for (int j = 0; j < trace_len; j++)
        acc += kern[(m + FFT_SIZE - j) % FFT_SIZE] * xs_store[j];
      v = round_div(acc, 64'sd1 << 27);
      if (!mode_adjoint) v = round_div(v * tw_store[m], 4096);
      if (mode_accum) v += prior_mem[m];
      r.sat = 1'b0;
      if (v > 32767) begin
        v = 32767;
        r.sat = 1'b1;
      end
      if (v < -32768) begin
        v = -32768;
        r.sat = 1'b1;
      end
      r.value = v[15:0];
      r.last = (m + 1 == trace_len);
      expected_q.push_back(r);
    end
    trace_len = 0;
    bin_idx = 0;
  endtask

  task automatic predict_beat(logic func, int x, int w, int fw, int pv, logic last);
    int i;
    if (func == FUNC_WEIGHT) begin
      bin_w[bin_idx] = fw;
      bin_idx = (bin_idx + 1 >= NW) ? 0 : bin_idx + 1;
    end else begin
      i = (trace_len >= FFT_SIZE) ? FFT_SIZE - 1 : trace_len;
      tw_store[i] = w;
      prior_mem[i] = pv;
      xs_store[i] = mode_adjoint ? round_div(longint'(x) * w, 4096) : x;
      trace_len = i + 1;
      if (last || trace_len >= FFT_SIZE) filter_trace();
    end
  endtask

  task automatic send_beat(logic func, int x, int w, int fw, int pv, logic last);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tlast  <= last;
    in_tdata  <= {pv[15:0], fw[15:0], w[15:0], x[15:0]};
    do @(posedge clk); while (!in_tready);
    predict_beat(func, x, w, fw, pv, last);
    items_sent++;
  endtask

  task automatic end_stream();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic write_reg(logic idx, logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_ADJOINT) mode_adjoint = val;
    else mode_accum = val;
  endtask

  task automatic drain();
    end_stream();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int rand_s16();
    return $signed(16'($urandom));
  endfunction

  task automatic load_weights(int cnt, int style);
    int fw;
    for (int k = 0; k < cnt; k++) begin
      case (style)
        0:       fw = 4096;
        1:       fw = rand_s16();
        default: fw = $urandom_range(1024) - 512;
      endcase
      send_beat(FUNC_WEIGHT, rand_s16(), rand_s16(), fw, rand_s16(),
                1'($urandom_range(1)));
    end
  endtask

  task automatic random_trace(int n, logic use_last);
    int x;
    int w;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(9) == 0)
        send_beat(FUNC_WEIGHT, rand_s16(), rand_s16(), rand_s16(), rand_s16(), 1'b0);
      x = ($urandom_range(1)) ? rand_s16() : $urandom_range(4000) - 2000;
      w = ($urandom_range(1)) ? rand_s16() : 4096 + $urandom_range(2000) - 1000;
      send_beat(FUNC_SAMPLE, x, w, rand_s16(), rand_s16(), use_last && (j == n - 1));
    end
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  always @(negedge clk) begin
    if (hold_start) begin
      hold_left = 3000;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    filt_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", $signed(out_tdata), 0);
      end else begin
        e = expected_q.pop_front();
        if (out_tdata !== e.value)
          report_mismatch("result_value", $signed(out_tdata), e.value);
        if (out_tlast !== e.last) report_mismatch("result_last", out_tlast, e.last);
        if (out_tuser !== e.sat) report_mismatch("saturated", out_tuser, e.sat);
      end
    end
  end

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_ADJOINT, 1'b0);
    write_reg(CFG_ACCUMULATE, 1'b0);
    load_weights(NW, 0);
    foreach (directed_rows[r]) begin
      send_beat(FUNC_SAMPLE, directed_rows[r].x, directed_rows[r].w, rand_s16(),
                directed_rows[r].pv, directed_rows[r].last);
      if (directed_rows[r].typed) begin
        expected_q[$].value = 16'(directed_rows[r].ev);
        expected_q[$].sat = directed_rows[r].es;
      end
    end
    drain();

    phase = 0;
    while (phase < 4 || items_sent < 170) begin
      write_reg(CFG_ADJOINT, phase[0]);
      write_reg(CFG_ACCUMULATE, phase[1]);
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 55; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 55; end
        default: begin gap_pct = 19; stall_pct = 19; end
      endcase
      if (phase == 1) hold_start = 1'b1;
      if ($urandom_range(2) == 0) load_weights(NW + $urandom_range(7), $urandom_range(2));
      else load_weights($urandom_range(1, NW), $urandom_range(2));
      if (phase == 3) random_trace(FFT_SIZE, 1'b0);
      repeat ($urandom_range(1, 3)) random_trace($urandom_range(1, 8), 1'b1);
      drain();
      phase++;
    end

    gap_pct = 0;
    stall_pct = 0;
    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("time_frequency_weight_filter test passed");
    end else begin
      $display("time_frequency_weight_filter test failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("time_frequency_weight_filter test failed");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tfwf_pkg.sv
hw/rtl/tfwf_ram.sv
hw/rtl/tfwf_queue.sv
hw/rtl/tfwf_front.sv
hw/rtl/tfwf_back.sv
hw/rtl/time_frequency_weight_filter.sv
bench/time_frequency_weight_filter_tb.sv
